// ===== src/flru_pkg.sv =====
// Shared types and constants for the fully associative LRU cache directory.
`default_nettype none

package flru_pkg;

   // Fixed field widths of the request and response beats
   localparam int TAG_IN_BITS = 32;
   localparam int WAY_OUT_BITS = 6;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Control strobes from the sequencer to the datapath
   typedef struct packed {
      logic accept_access;
      logic accept_flush;
      logic rd_issue;
      logic scan_phase;
      logic upd_phase;
      logic decide;
      logic finish;
      logic load_out;
   } seq_ctl_type;

endpackage

`default_nettype wire

// ===== src/flru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module flru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/flru_seq.sv =====
// Sequencer: walks the ways twice per access (scan, then rank update).
`default_nettype none

module flru_seq #(
   parameter int WAYS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_action,
   input  wire logic                         rsp_busy,
   output logic                              req_stall,
   output flru_pkg::seq_ctl_type             ctl,
   output logic      [$clog2(WAYS)-1:0]      way_idx
);

   import flru_pkg::*;

   localparam int IW = $clog2(WAYS);

   state_type      state_ff, state_in;
   logic [IW-1:0]  cnt_ff, cnt_in;
   logic           last_way;

   assign last_way = (cnt_ff == IW'(WAYS - 1));
   assign way_idx  = cnt_ff;
   assign req_stall = (state_ff != ST_IDLE);

   // State and way counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and control strobes
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               if (req_action) begin
                  ctl.accept_flush = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  ctl.accept_access = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.rd_issue   = 1'b1;
            ctl.scan_phase = 1'b1;
            cnt_in = cnt_ff + IW'(1);
            if (last_way) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ctl.scan_phase = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            ctl.decide = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctl.rd_issue  = 1'b1;
            ctl.upd_phase = 1'b1;
            cnt_in = cnt_ff + IW'(1);
            if (last_way) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.upd_phase = 1'b1;
            ctl.finish    = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_busy) begin
               ctl.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/fully_associative_lru_cache.sv =====
// Top level of the fully associative cache directory with true LRU replacement.
// An access makes one scan pass over the tag and rank RAMs, then one read-modify-write
//   rank pass; a flush clears all valid bits and answers without a pass. A new beat is
//   taken only in idle, after the previous result has gone to the output register, and
//   it is taken while the previous response waits.
// Reset clears all valid bits and the sequencer at once; no clearing pass is needed.
`default_nettype none

module fully_associative_lru_cache #(
   parameter int WAYS     = 64,
   parameter int TAG_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_action,
   input  wire logic [flru_pkg::TAG_IN_BITS-1:0]      req_tag,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic      [flru_pkg::WAY_OUT_BITS-1:0]     rsp_way
);

   import flru_pkg::*;

   localparam int IW = $clog2(WAYS);
   localparam int RW = IW + 1;
   localparam int TW = (TAG_BITS > TAG_IN_BITS) ? TAG_BITS : TAG_IN_BITS;
   localparam int WW = (IW > WAY_OUT_BITS) ? IW : WAY_OUT_BITS;

   seq_ctl_type       ctl;
   logic [IW-1:0]     way_idx;
   logic              rsp_busy;

   logic [WAYS-1:0]   valid_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TW-1:0]     tag_wide;

   logic              data_vld_ff;
   logic [IW-1:0]     data_idx_ff;
   logic [TAG_BITS-1:0] tag_rd;
   logic [IW-1:0]     age_rd;

   logic              hit_ff;
   logic [IW-1:0]     hit_way_ff;
   logic [IW-1:0]     hit_rank_ff;
   logic              free_ff;
   logic [IW-1:0]     free_way_ff;
   logic [IW-1:0]     old_way_ff;
   logic [IW-1:0]     old_rank_ff;

   logic [IW-1:0]     target_ff, target_in;
   logic [RW-1:0]     rank_ff, rank_in;

   logic              res_hit_ff;
   logic [IW-1:0]     res_way_ff;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [WAY_OUT_BITS-1:0] rsp_way_ff;
   logic [WW-1:0]     res_way_wide;

   logic              entry_valid;
   logic              age_we;
   logic [IW-1:0]     age_wdata;

   assign rsp_busy = rsp_valid_ff & rsp_stall;
   assign tag_wide = TW'(req_tag);

   flru_seq #(
      .WAYS (WAYS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .rsp_busy   (rsp_busy),
      .req_stall  (req_stall),
      .ctl        (ctl),
      .way_idx    (way_idx)
   );

   // Tag store: written on a miss at decide time, read during the scan
   flru_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (WAYS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ctl.decide & ~hit_ff),
      .wr_addr (target_in),
      .wr_data (tag_ff),
      .rd_en   (ctl.rd_issue & ctl.scan_phase),
      .rd_addr (way_idx),
      .rd_data (tag_rd)
   );

   // Rank store: read in both passes, rewritten one way behind the read in the update pass
   flru_ram #(
      .WIDTH (IW),
      .DEPTH (WAYS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (data_idx_ff),
      .wr_data (age_wdata),
      .rd_en   (ctl.rd_issue),
      .rd_addr (way_idx),
      .rd_data (age_rd)
   );

   // Read pipeline tracking: which way's data sits on the RAM outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= 1'b0;
      end else begin
         data_vld_ff <= ctl.rd_issue;
      end
      data_idx_ff <= way_idx;
   end

   assign entry_valid = valid_ff[data_idx_ff];

   // Latch the request tag, masked to the stored width
   always_ff @(posedge clock) begin
      if (ctl.accept_access) begin
         tag_ff <= tag_wide[TAG_BITS-1:0];
      end
   end

   // Scan pass: first matching valid way, first invalid way, highest rank
   always_ff @(posedge clock) begin
      if (ctl.accept_access) begin
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         old_way_ff  <= '0;
         old_rank_ff <= '0;
      end else if (ctl.scan_phase && data_vld_ff) begin
         if (entry_valid && !hit_ff && (tag_rd == tag_ff)) begin
            hit_ff      <= 1'b1;
            hit_way_ff  <= data_idx_ff;
            hit_rank_ff <= age_rd;
         end
         if (!entry_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_way_ff <= data_idx_ff;
         end
         if (entry_valid && (age_rd > old_rank_ff)) begin
            old_way_ff  <= data_idx_ff;
            old_rank_ff <= age_rd;
         end
      end
   end

   // Victim choice and the rank below which valid ways age by one
   always_comb begin
      target_in = target_ff;
      rank_in   = rank_ff;
      if (ctl.decide) begin
         if (hit_ff) begin
            target_in = hit_way_ff;
            rank_in   = {1'b0, hit_rank_ff};
         end else if (free_ff) begin
            target_in = free_way_ff;
            rank_in   = RW'(WAYS);
         end else begin
            target_in = old_way_ff;
            rank_in   = {1'b0, old_rank_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      rank_ff   <= rank_in;
   end

   // Update pass: target becomes most recent, younger valid ways age by one
   always_comb begin
      age_we    = ctl.upd_phase & data_vld_ff;
      age_wdata = age_rd;
      if (data_idx_ff == target_ff) begin
         age_wdata = '0;
      end else if (entry_valid && ({1'b0, age_rd} < rank_ff)) begin
         age_wdata = age_rd + IW'(1);
      end
   end

   // Valid bits: cleared on reset and flush, set when a way is filled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.accept_flush) begin
         valid_ff <= '0;
      end else if (ctl.finish) begin
         valid_ff[target_ff] <= 1'b1;
      end
   end

   // Result staging
   always_ff @(posedge clock) begin
      if (ctl.accept_flush) begin
         res_hit_ff <= 1'b0;
         res_way_ff <= '0;
      end else if (ctl.decide) begin
         res_hit_ff <= hit_ff;
         res_way_ff <= target_in;
      end
   end

   assign res_way_wide = WW'(res_way_ff);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_way_ff <= res_way_wide[WAY_OUT_BITS-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_way   = rsp_way_ff;

endmodule

`default_nettype wire
